// ===== hdl/dta_pkg.sv =====
// shared types and constants of the descriptor table allocator
package dta_pkg;

  // field widths fixed by the interface
  localparam int FD_W     = 8;
  localparam int HANDLE_W = 16;
  localparam int RFD_W    = 7;
  localparam int HINT_W   = 7;

  localparam logic [HINT_W-1:0] HINT_MAX = 7'd127;

  // operation codes
  typedef enum logic [2:0] {
    MODE_ALLOC       = 3'd0,
    MODE_RELEASE     = 3'd1,
    MODE_INSTALL     = 3'd2,
    MODE_GET         = 3'd3,
    MODE_DUP2        = 3'd4,
    MODE_DUPFD       = 3'd5,
    MODE_GET_CLOEXEC = 3'd6,
    MODE_SET_CLOEXEC = 3'd7
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADFD = 2'd1,
    ST_FULL  = 2'd2,
    ST_INVAL = 2'd3
  } status_t;

  // one result word
  typedef struct packed {
    status_t               status;
    logic [RFD_W-1:0]      result_fd;
    logic [HANDLE_W-1:0]   result_handle;
    logic                  flag;
    logic                  ref_taken;
    logic [HANDLE_W-1:0]   drop_handle;
  } res_t;

endpackage

// ===== hdl/descriptor_table_allocator.sv =====
// descriptor table allocator top level: input register, operation logic, result register
//
// Input words carry an operation (alloc, release, install, get, dup2, dupfd,
// get/set close-on-exec) with its descriptors, handle and close-on-exec bit.
// Each input word gives exactly one result word, in order.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The input register captures an accepted word while the handle store is read
// at fd and second_fd; when the word advances, the operation executes against
// the bitmaps and the result register is written. Throughput is one word per cycle
// while the result side does not stall; the free-slot search is a priority
// encoder over the open bitmap and the handle store has one write port.
// A stall on the result side holds the result register; the input register
// then holds its word and in_stall rises once both are full.
// Synchronous reset (rst_n low) empties the pipeline, clears the open and
// close-on-exec bitmaps and the allocation hint, and marks every handle
// slot empty; the block takes words as soon as reset is released.
module descriptor_table_allocator #(
  parameter int TABLE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dta_pkg::mode_t                       in_mode,
  input  logic signed [dta_pkg::FD_W-1:0]      in_fd,
  input  logic signed [dta_pkg::FD_W-1:0]      in_second_fd,
  input  logic [dta_pkg::HANDLE_W-1:0]         in_handle,
  input  logic                                 in_cloexec,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dta_pkg::status_t                     out_status,
  output logic [dta_pkg::RFD_W-1:0]            out_result_fd,
  output logic [dta_pkg::HANDLE_W-1:0]         out_result_handle,
  output logic                                 out_flag,
  output logic                                 out_ref_taken,
  output logic [dta_pkg::HANDLE_W-1:0]         out_drop_handle
);

  import dta_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam logic [FD_W-1:0] DEPTH_L = FD_W'(TABLE_DEPTH);

  // pipeline control
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              in_acc;
  logic              adv;

  // input register
  mode_t             s1_mode_r;
  logic [FD_W-1:0]   s1_fd_r;
  logic [FD_W-1:0]   s1_fd2_r;
  logic [SW-1:0]     s1_handle_r;
  logic              s1_cloexec_r;

  // table state
  logic [TABLE_DEPTH-1:0] open_r, open_nxt;
  logic [TABLE_DEPTH-1:0] exec_r, exec_nxt;
  logic [HINT_W-1:0]      hint_r, hint_nxt;

  // result register
  res_t              res_r, res_nxt;

  // handle store interface
  logic              wr_req;
  logic [IDX_W-1:0]  wr_addr;
  logic [SW-1:0]     wr_data;
  logic [SW-1:0]     rd_a;
  logic [SW-1:0]     rd_b;

  // operation decode helpers
  logic              fd_ok, fd2_ok;
  logic [IDX_W-1:0]  fd_idx, fd2_idx;
  logic [7:0]        search_start;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [7:0]        free_next;

  // handshake
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // input register capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r    <= in_mode;
      s1_fd_r      <= in_fd;
      s1_fd2_r     <= in_second_fd;
      s1_handle_r  <= in_handle[SW-1:0];
      s1_cloexec_r <= in_cloexec;
    end
  end

  // handle store, read at capture and written when the word executes
  dta_handle_ram #(
    .DEPTH  (TABLE_DEPTH),
    .IDX_W  (IDX_W),
    .DATA_W (SW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (adv && wr_req),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (in_acc),
    .ra_addr (in_fd[IDX_W-1:0]),
    .rb_addr (in_second_fd[IDX_W-1:0]),
    .ra_data (rd_a),
    .rb_data (rd_b)
  );

  // range checks on the signed descriptors
  assign fd_ok   = !s1_fd_r[FD_W-1] && (s1_fd_r < DEPTH_L);
  assign fd2_ok  = !s1_fd2_r[FD_W-1] && (s1_fd2_r < DEPTH_L);
  assign fd_idx  = s1_fd_r[IDX_W-1:0];
  assign fd2_idx = s1_fd2_r[IDX_W-1:0];

  // shared free-slot search, from the hint for alloc and from second_fd for dupfd
  assign search_start = (s1_mode_r == MODE_ALLOC) ? {1'b0, hint_r} : s1_fd2_r;

  dta_free_find #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_find (
    .open_map (open_r),
    .start    (search_start),
    .found    (free_found),
    .idx      (free_idx)
  );

  assign free_next = 8'(free_idx) + 8'd1;

  // operation execute
  always_comb begin
    open_nxt = open_r;
    exec_nxt = exec_r;
    hint_nxt = hint_r;
    res_nxt  = '0;
    res_nxt.status = ST_OK;
    wr_req   = 1'b0;
    wr_addr  = fd_idx;
    wr_data  = s1_handle_r;
    case (s1_mode_r)
      MODE_ALLOC: begin
        if (!free_found) begin
          res_nxt.status = ST_FULL;
        end else begin
          open_nxt[free_idx] = 1'b1;
          exec_nxt[free_idx] = s1_cloexec_r;
          hint_nxt = (free_next > 8'(HINT_MAX)) ? HINT_MAX : free_next[HINT_W-1:0];
          res_nxt.result_fd = RFD_W'(free_idx);
        end
      end
      MODE_RELEASE: begin
        if (!fd_ok) begin
          res_nxt.status = ST_BADFD;
        end else begin
          open_nxt[fd_idx] = 1'b0;
          if (s1_fd_r[HINT_W-1:0] < hint_r) begin
            hint_nxt = s1_fd_r[HINT_W-1:0];
          end
          res_nxt.result_fd = s1_fd_r[RFD_W-1:0];
        end
      end
      MODE_INSTALL: begin
        if (!fd_ok) begin
          res_nxt.status = ST_FULL;
        end else begin
          wr_req  = 1'b1;
          wr_addr = fd_idx;
          wr_data = s1_handle_r;
          res_nxt.result_fd = s1_fd_r[RFD_W-1:0];
        end
      end
      MODE_GET: begin
        if (!fd_ok || (rd_a == '0)) begin
          res_nxt.status = ST_BADFD;
        end else begin
          res_nxt.result_handle = HANDLE_W'(rd_a);
          res_nxt.ref_taken     = 1'b1;
          res_nxt.result_fd     = s1_fd_r[RFD_W-1:0];
        end
      end
      MODE_DUP2: begin
        if (!fd_ok || (rd_a == '0)) begin
          res_nxt.status = ST_BADFD;
        end else if (s1_fd_r == s1_fd2_r) begin
          res_nxt.result_fd = s1_fd_r[RFD_W-1:0];
        end else if (!fd2_ok) begin
          res_nxt.status = ST_BADFD;
        end else begin
          wr_req  = 1'b1;
          wr_addr = fd2_idx;
          wr_data = rd_a;
          open_nxt[fd2_idx] = 1'b1;
          exec_nxt[fd2_idx] = 1'b0;
          res_nxt.result_handle = HANDLE_W'(rd_a);
          res_nxt.drop_handle   = HANDLE_W'(rd_b);
          res_nxt.ref_taken     = 1'b1;
          res_nxt.result_fd     = s1_fd2_r[RFD_W-1:0];
        end
      end
      MODE_DUPFD, MODE_GET_CLOEXEC, MODE_SET_CLOEXEC: begin
        if (!fd_ok || !open_r[fd_idx]) begin
          res_nxt.status = ST_BADFD;
        end else if (s1_mode_r == MODE_DUPFD) begin
          if (!fd2_ok) begin
            res_nxt.status = ST_INVAL;
          end else if (!free_found) begin
            res_nxt.status = ST_FULL;
          end else begin
            wr_req  = 1'b1;
            wr_addr = free_idx;
            wr_data = rd_a;
            open_nxt[free_idx] = 1'b1;
            exec_nxt[free_idx] = 1'b0;
            res_nxt.result_handle = HANDLE_W'(rd_a);
            res_nxt.ref_taken     = (rd_a != '0);
            res_nxt.result_fd     = RFD_W'(free_idx);
          end
        end else if (s1_mode_r == MODE_GET_CLOEXEC) begin
          res_nxt.flag      = exec_r[fd_idx];
          res_nxt.result_fd = s1_fd_r[RFD_W-1:0];
        end else begin
          exec_nxt[fd_idx]  = s1_fd2_r[0];
          res_nxt.result_fd = s1_fd_r[RFD_W-1:0];
        end
      end
      default: begin
        res_nxt.status = ST_INVAL;
      end
    endcase
  end

  // table state update, once per executed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      exec_r <= '0;
      hint_r <= '0;
    end else if (adv) begin
      open_r <= open_nxt;
      exec_r <= exec_nxt;
      hint_r <= hint_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_result_fd     = res_r.result_fd;
  assign out_result_handle = res_r.result_handle;
  assign out_flag          = res_r.flag;
  assign out_ref_taken     = res_r.ref_taken;
  assign out_drop_handle   = res_r.drop_handle;

endmodule

// ===== hdl/dta_handle_ram.sv =====
// handle store: one write port, two registered read ports, per-entry valid bits
module dta_handle_ram #(
  parameter int DEPTH  = 64,
  parameter int IDX_W  = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  ra_addr,
  input  logic [IDX_W-1:0]  rb_addr,
  output logic [DATA_W-1:0] ra_data,
  output logic [DATA_W-1:0] rb_data
);

  logic [DATA_W-1:0] handle_mem_r [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] ra_data_r;
  logic [DATA_W-1:0] rb_data_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (we) begin
      handle_mem_r[waddr] <= wdata;
    end
  end

  // written entries, cleared at reset so unwritten slots read zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // registered reads, a same-cycle write is passed through
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == ra_addr)) begin
        ra_data_r <= wdata;
      end else if (vld_r[ra_addr]) begin
        ra_data_r <= handle_mem_r[ra_addr];
      end else begin
        ra_data_r <= '0;
      end
      if (we && (waddr == rb_addr)) begin
        rb_data_r <= wdata;
      end else if (vld_r[rb_addr]) begin
        rb_data_r <= handle_mem_r[rb_addr];
      end else begin
        rb_data_r <= '0;
      end
    end
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

// ===== hdl/dta_free_find.sv =====
// lowest clear bit of the open bitmap at or above a start position
module dta_free_find #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic [DEPTH-1:0] open_map,
  input  logic [7:0]       start,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  logic [DEPTH-1:0] cand;

  // free slots at or above the start
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cand[i] = !open_map[i] && (8'(i) >= start);
    end
  end

  // priority encoder, lowest index wins
  always_comb begin
    idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign found = |cand;

endmodule
